// File: rtl/ece_pkg.sv
`timescale 1ns / 1ps
package ece_pkg;

	localparam int FRAC_BITS      = 16;
	localparam int EXP_TABLE_BITS = 8;
	localparam int Q30            = 30;
	localparam int IN_W           = FRAC_BITS + 4;
	localparam int OUT_W          = FRAC_BITS + 2;
	localparam int PW             = FRAC_BITS + 8;
	localparam int SW             = PW + 1;
	localparam int EXP_SIZE       = 1 << EXP_TABLE_BITS;
	localparam int EXP_IDX_W      = EXP_TABLE_BITS + 1;
	localparam int EXP_ENT_W      = Q30 + 2;

	typedef logic [PW-1:0]        ece_pw_t;
	typedef logic signed [SW-1:0] ece_sval_t;

	localparam ece_pw_t ONE = ece_pw_t'(1) << FRAC_BITS;
	localparam ece_pw_t BACK_C1 = PW'((64'd170158 * (64'd1 << FRAC_BITS) + 64'd50000)
		/ 64'd100000);
	localparam ece_pw_t BACK_C3 = BACK_C1 + ONE;

	typedef enum logic [3:0] {
		KIND_LINEAR,
		KIND_CUBIC_IN,
		KIND_CUBIC_OUT,
		KIND_CUBIC_INOUT,
		KIND_QUINT_IN,
		KIND_QUINT_OUT,
		KIND_QUINT_INOUT,
		KIND_EXPO_IN,
		KIND_EXPO_OUT,
		KIND_EXPO_INOUT,
		KIND_BACK_IN,
		KIND_BACK_OUT,
		KIND_BACK_INOUT,
		KIND_BOUNCE_IN,
		KIND_BOUNCE_OUT,
		KIND_BOUNCE_INOUT
	} ece_kind_t;

	typedef enum logic [1:0] {
		BNC_LOW,
		BNC_MID,
		BNC_HIGH,
		BNC_TAIL
	} ece_bnc_t;

	typedef struct packed {
		ece_kind_t            kind;
		logic                 low;
		logic                 t_zero;
		logic                 t_one;
		logic [FRAC_BITS:0]   t;
	} ece_ctrl_t;

	typedef struct packed {
		logic s2;
		logic s3;
		logic s4;
		logic s5;
	} ece_adv_t;

	typedef logic [EXP_ENT_W-1:0] exp_ent_t;
	typedef exp_ent_t exp_tab_t [0:EXP_SIZE];

	// Fixed-point product with round half up on nonnegative operands.
	function automatic ece_pw_t mulq(input ece_pw_t a, input ece_pw_t b);
		logic [2*PW-1:0] p;
		begin
			p = (2*PW)'(a) * (2*PW)'(b) + ((2*PW)'(1) << (FRAC_BITS - 1));
			return p[FRAC_BITS+PW-1:FRAC_BITS];
		end
	endfunction

	// Halving with round half away from zero.
	function automatic ece_sval_t halve(input ece_sval_t v);
		ece_sval_t n;
		begin
			n = -v;
			if (!v[SW-1])
				return (v + ece_sval_t'(1)) >>> 1;
			return -((n + ece_sval_t'(1)) >>> 1);
		end
	endfunction

	function automatic logic [63:0] isqrt64(input logic [63:0] n_in);
		logic [63:0] n;
		logic [63:0] res;
		logic [63:0] bit_v;
		begin
			n = n_in;
			res = 64'd0;
			bit_v = 64'd1 << 62;
			for (int i = 0; i < 32; i++) begin
				if (n >= res + bit_v) begin
					n = n - (res + bit_v);
					res = (res >> 1) + bit_v;
				end else begin
					res = res >> 1;
				end
				bit_v = bit_v >> 2;
			end
			return res;
		end
	endfunction

	// Table of 2^(k/2^EXP_TABLE_BITS) in Q30, built from repeated square roots of 2.
	function automatic exp_tab_t exp_table();
		exp_tab_t tab;
		logic [63:0] roots [0:EXP_TABLE_BITS];
		logic [63:0] e;
		begin
			roots[0] = 64'd2 << Q30;
			for (int j = 1; j <= EXP_TABLE_BITS; j++)
				roots[j] = isqrt64(roots[j-1] << Q30);
			for (int k = 0; k < EXP_SIZE; k++) begin
				e = 64'd1 << Q30;
				for (int j = 1; j <= EXP_TABLE_BITS; j++) begin
					if (((k >> (EXP_TABLE_BITS - j)) & 1) != 0)
						e = (e * roots[j] + (64'd1 << (Q30 - 1))) >> Q30;
				end
				tab[k] = EXP_ENT_W'(e);
			end
			tab[EXP_SIZE] = EXP_ENT_W'(64'd2 << Q30);
			return tab;
		end
	endfunction

	localparam exp_tab_t EXP_TAB = exp_table();

endpackage

// File: rtl/easing_curve_evaluator_top.sv
`timescale 1ns / 1ps
// Throughput: one word per cycle unless out_ready stalls it; each of the six register
// stages advances whenever it is empty or the stage after it advances, so bubbles
// close up under a stall. An accepted word passes stages 1 to 6 to reach the output.
// Reset: arst_n clears the stage valid bits only; the datapath registers keep no reset.
module easing_curve_evaluator_top (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic [3:0]                    curve_kind,
	input  logic signed [ece_pkg::IN_W-1:0] t_value,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic signed [ece_pkg::OUT_W-1:0] eased_value
);
	import ece_pkg::*;

	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6;
	logic adv1, adv6;
	ece_adv_t adv;

	ece_ctrl_t ctrl;
	ece_ctrl_t ctrl_s1, ctrl_s2, ctrl_s3, ctrl_s4, ctrl_s5;
	ece_pw_t   x;
	ece_pw_t   x_s1;
	logic [IN_W-1:0] m;
	logic [IN_W-1:0] m_s1;
	logic [FRAC_BITS:0] tc;
	ece_pw_t   t_w, two_t, ten_t, twenty_t;

	ece_pw_t   p3_s5, p5_s5;
	ece_sval_t core_s5;
	logic [OUT_W-1:0] bo_s5, e_s5;
	ece_sval_t one_s, p3_v, p5_v, bo_v, e_v, y;
	logic signed [OUT_W-1:0] y_s6;

	always_comb begin
		adv6   = !v_s6 || out_ready;
		adv.s5 = !v_s5 || adv6;
		adv.s4 = !v_s4 || adv.s5;
		adv.s3 = !v_s3 || adv.s4;
		adv.s2 = !v_s2 || adv.s3;
		adv1   = !v_s1 || adv.s2;
	end
	assign in_ready = adv1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
		end else begin
			if (adv1)   v_s1 <= in_valid;
			if (adv.s2) v_s2 <= v_s1;
			if (adv.s3) v_s3 <= v_s2;
			if (adv.s4) v_s4 <= v_s3;
			if (adv.s5) v_s5 <= v_s4;
			if (adv6)   v_s6 <= v_s5;
		end
	end

	// Stage 1: clamp t and form the argument of each curve family.
	always_comb begin
		if (t_value[IN_W-1])
			tc = '0;
		else if (t_value > $signed(IN_W'(ONE)))
			tc = (FRAC_BITS+1)'(ONE);
		else
			tc = t_value[FRAC_BITS:0];
		t_w      = PW'(tc);
		two_t    = t_w << 1;
		ten_t    = (t_w << 3) + (t_w << 1);
		twenty_t = ten_t << 1;

		ctrl.kind   = ece_kind_t'(curve_kind);
		ctrl.low    = two_t < ONE;
		ctrl.t_zero = tc == '0;
		ctrl.t_one  = t_w == ONE;
		ctrl.t      = tc;

		x = '0;
		m = '0;
		unique case (ctrl.kind)
			KIND_CUBIC_IN, KIND_QUINT_IN, KIND_BACK_IN, KIND_BOUNCE_OUT:
				x = t_w;
			KIND_CUBIC_OUT, KIND_QUINT_OUT, KIND_BACK_OUT, KIND_BOUNCE_IN:
				x = ONE - t_w;
			KIND_CUBIC_INOUT, KIND_QUINT_INOUT, KIND_BACK_INOUT:
				x = ctrl.low ? two_t : (ONE << 1) - two_t;
			KIND_BOUNCE_INOUT:
				x = ctrl.low ? ONE - two_t : two_t - ONE;
			KIND_EXPO_IN:
				m = IN_W'(10 * ONE - ten_t);
			KIND_EXPO_OUT:
				m = IN_W'(ten_t);
			KIND_EXPO_INOUT:
				m = ctrl.low ? IN_W'(10 * ONE - twenty_t) : IN_W'(twenty_t - 10 * ONE);
			KIND_LINEAR: ;
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (adv1) begin
			ctrl_s1 <= ctrl;
			x_s1    <= x;
			m_s1    <= m;
		end
		if (adv.s2) ctrl_s2 <= ctrl_s1;
		if (adv.s3) ctrl_s3 <= ctrl_s2;
		if (adv.s4) ctrl_s4 <= ctrl_s3;
		if (adv.s5) ctrl_s5 <= ctrl_s4;
		if (adv6)   y_s6    <= y[OUT_W-1:0];
	end

	ece_poly u_poly (
		.clk     (clk),
		.adv     (adv),
		.x_s1    (x_s1),
		.p3_s5   (p3_s5),
		.p5_s5   (p5_s5),
		.core_s5 (core_s5)
	);

	ece_bounce u_bounce (
		.clk   (clk),
		.adv   (adv),
		.x_s1  (x_s1[FRAC_BITS:0]),
		.bo_s5 (bo_s5)
	);

	ece_exp2 u_exp2 (
		.clk  (clk),
		.adv  (adv),
		.m_s1 (m_s1),
		.e_s5 (e_s5)
	);

	// Stage 6: fold each family back into its in, out or in-out form.
	always_comb begin
		one_s = ece_sval_t'(ONE);
		p3_v  = ece_sval_t'(p3_s5);
		p5_v  = ece_sval_t'(p5_s5);
		bo_v  = ece_sval_t'(bo_s5);
		e_v   = ece_sval_t'(e_s5);
		unique case (ctrl_s5.kind)
			KIND_LINEAR:       y = ece_sval_t'(ctrl_s5.t);
			KIND_CUBIC_IN:     y = p3_v;
			KIND_CUBIC_OUT:    y = one_s - p3_v;
			KIND_CUBIC_INOUT:  y = ctrl_s5.low ? halve(p3_v) : one_s - halve(p3_v);
			KIND_QUINT_IN:     y = p5_v;
			KIND_QUINT_OUT:    y = one_s - p5_v;
			KIND_QUINT_INOUT:  y = ctrl_s5.low ? halve(p5_v) : one_s - halve(p5_v);
			KIND_EXPO_IN:      y = ctrl_s5.t_zero ? '0 : e_v;
			KIND_EXPO_OUT:     y = ctrl_s5.t_one ? one_s : one_s - e_v;
			KIND_EXPO_INOUT: begin
				priority if (ctrl_s5.t_zero)
					y = '0;
				else if (ctrl_s5.t_one)
					y = one_s;
				else if (ctrl_s5.low)
					y = halve(e_v);
				else
					y = one_s - halve(e_v);
			end
			KIND_BACK_IN:      y = core_s5;
			KIND_BACK_OUT:     y = one_s - core_s5;
			KIND_BACK_INOUT:
				y = ctrl_s5.low ? halve(core_s5) : halve((one_s <<< 1) - core_s5);
			KIND_BOUNCE_IN:    y = one_s - bo_v;
			KIND_BOUNCE_OUT:   y = bo_v;
			KIND_BOUNCE_INOUT:
				y = ctrl_s5.low ? halve(one_s - bo_v) : halve(one_s + bo_v);
			default:           y = '0;
		endcase
	end

	assign out_valid   = v_s6;
	assign eased_value = y_s6;

endmodule

// File: rtl/ece_poly.sv
`timescale 1ns / 1ps
module ece_poly (
	input  logic              clk,
	input  ece_pkg::ece_adv_t adv,
	input  ece_pkg::ece_pw_t  x_s1,
	output ece_pkg::ece_pw_t  p3_s5,
	output ece_pkg::ece_pw_t  p5_s5,
	output ece_pkg::ece_sval_t core_s5
);
	import ece_pkg::*;

	ece_pw_t   x_s2, x_s3, x_s4;
	ece_pw_t   p2_s2, p2_s3;
	ece_pw_t   p3_s3, p3_s4;
	ece_pw_t   p4_s4;
	ece_pw_t   a_s4, b_s4;

	// One multiply per stage along the power chain; the back terms run beside it.
	always_ff @(posedge clk) begin
		if (adv.s2) begin
			x_s2  <= x_s1;
			p2_s2 <= mulq(x_s1, x_s1);
		end
		if (adv.s3) begin
			x_s3  <= x_s2;
			p2_s3 <= p2_s2;
			p3_s3 <= mulq(p2_s2, x_s2);
		end
		if (adv.s4) begin
			x_s4  <= x_s3;
			p3_s4 <= p3_s3;
			p4_s4 <= mulq(p3_s3, x_s3);
			a_s4  <= mulq(BACK_C3, p3_s3);
			b_s4  <= mulq(BACK_C1, p2_s3);
		end
		if (adv.s5) begin
			p3_s5   <= p3_s4;
			p5_s5   <= mulq(p4_s4, x_s4);
			core_s5 <= $signed({1'b0, a_s4}) - $signed({1'b0, b_s4});
		end
	end

endmodule

// File: rtl/ece_bounce.sv
`timescale 1ns / 1ps
module ece_bounce (
	input  logic                          clk,
	input  ece_pkg::ece_adv_t             adv,
	input  logic [ece_pkg::FRAC_BITS:0]   x_s1,
	output logic [ece_pkg::OUT_W-1:0]     bo_s5
);
	import ece_pkg::*;

	localparam int XW = FRAC_BITS + 5;
	localparam int DW = FRAC_BITS + 8;

	logic [XW-1:0]         x11;
	logic signed [DW-1:0]  d;
	ece_bnc_t              br;
	logic [2*DW-1:0]       sq;
	logic [2*DW-1:0]       sq_n, sq_t;
	logic [OUT_W-1:0]      sq_r;
	logic [OUT_W-1:0]      ofs;

	logic signed [DW-1:0]  d_s2;
	ece_bnc_t              br_s2, br_s3;
	logic [OUT_W-1:0]      sq_s3;
	logic [OUT_W-1:0]      bo_s4;

	always_comb begin
		x11 = (XW'(x_s1) << 3) + (XW'(x_s1) << 1) + XW'(x_s1);
		priority if (x11 < XW'(4 * ONE)) begin
			br = BNC_LOW;
			d  = $signed(DW'(x11));
		end else if (x11 < XW'(8 * ONE)) begin
			br = BNC_MID;
			d  = $signed(DW'(x11)) - $signed(DW'(6 * ONE));
		end else if (x11 < XW'(10 * ONE)) begin
			br = BNC_HIGH;
			d  = $signed(DW'(x11)) - $signed(DW'(9 * ONE));
		end else begin
			br = BNC_TAIL;
			d  = $signed(DW'(x11) << 1) - $signed(DW'(21 * ONE));
		end
	end

	always_comb begin
		sq   = $unsigned((2*DW)'(d_s2) * (2*DW)'(d_s2));
		sq_n = (sq + ((2*DW)'(1) << (FRAC_BITS + 3))) >> (FRAC_BITS + 4);
		sq_t = (sq + ((2*DW)'(1) << (FRAC_BITS + 5))) >> (FRAC_BITS + 6);
		sq_r = (br_s2 == BNC_TAIL) ? sq_t[OUT_W-1:0] : sq_n[OUT_W-1:0];
	end

	always_comb begin
		unique case (br_s3)
			BNC_LOW:  ofs = '0;
			BNC_MID:  ofs = OUT_W'(3 * (ONE >> 2));
			BNC_HIGH: ofs = OUT_W'(15 * (ONE >> 4));
			BNC_TAIL: ofs = OUT_W'(63 * (ONE >> 6));
			default:  ofs = '0;
		endcase
	end

	always_ff @(posedge clk) begin
		if (adv.s2) begin
			d_s2  <= d;
			br_s2 <= br;
		end
		if (adv.s3) begin
			sq_s3 <= sq_r;
			br_s3 <= br_s2;
		end
		if (adv.s4)
			bo_s4 <= sq_s3 + ofs;
		if (adv.s5)
			bo_s5 <= bo_s4;
	end

endmodule

// File: rtl/ece_exp2.sv
`timescale 1ns / 1ps
module ece_exp2 (
	input  logic                          clk,
	input  ece_pkg::ece_adv_t             adv,
	input  logic [ece_pkg::IN_W-1:0]      m_s1,
	output logic [ece_pkg::OUT_W-1:0]     e_s5
);
	import ece_pkg::*;

	localparam int RW  = FRAC_BITS - EXP_TABLE_BITS;
	localparam int IPW = IN_W - FRAC_BITS + 1;
	localparam int SHW = IPW + 1;
	localparam int PRW = EXP_ENT_W + RW;

	logic [IPW-1:0]        ip;
	logic [FRAC_BITS-1:0]  fp;
	logic [EXP_IDX_W-1:0]  k0, k1;
	logic [PRW-1:0]        prod;
	logic [SHW-1:0]        sh;
	logic [EXP_ENT_W:0]    rnd;
	logic [EXP_ENT_W:0]    shifted;

	logic [IPW-1:0]        ip_s2, ip_s3;
	logic [RW-1:0]         r_s2;
	exp_ent_t              e0_s2, e1_s2;
	exp_ent_t              v_s3;
	logic [OUT_W-1:0]      e_s4;

	// x = -q + f: a nonzero fraction borrows one from the integer part.
	always_comb begin
		ip = IPW'(m_s1 >> FRAC_BITS);
		fp = m_s1[FRAC_BITS-1:0];
		if (fp != '0) begin
			ip = ip + IPW'(1);
			fp = FRAC_BITS'(ONE - ece_pw_t'(fp));
		end
		k0 = EXP_IDX_W'(fp[FRAC_BITS-1:RW]);
		k1 = k0 + EXP_IDX_W'(1);
	end

	always_comb begin
		prod = PRW'(e1_s2 - e0_s2) * PRW'(r_s2) + (PRW'(1) << (RW - 1));
	end

	always_comb begin
		sh      = SHW'(ip_s3) + SHW'(Q30 - FRAC_BITS);
		rnd     = (EXP_ENT_W+1)'(v_s3) + ((EXP_ENT_W+1)'(1) << (sh - SHW'(1)));
		shifted = rnd >> sh;
	end

	always_ff @(posedge clk) begin
		if (adv.s2) begin
			ip_s2 <= ip;
			r_s2  <= fp[RW-1:0];
			e0_s2 <= EXP_TAB[k0];
			e1_s2 <= EXP_TAB[k1];
		end
		if (adv.s3) begin
			ip_s3 <= ip_s2;
			v_s3  <= e0_s2 + EXP_ENT_W'(prod >> RW);
		end
		if (adv.s4)
			e_s4 <= shifted[OUT_W-1:0];
		if (adv.s5)
			e_s5 <= e_s4;
	end

endmodule
